FILE: rtl/core/crc16_packet_deframer_assert.svh
// ----------------------------------------------------------------------------
// crc16_packet_deframer assertion macros
// clocked property checks used by the deframer queue
// ----------------------------------------------------------------------------
`ifndef CRC16_PACKET_DEFRAMER_ASSERT_SVH
`define CRC16_PACKET_DEFRAMER_ASSERT_SVH

// property must hold at every edge outside reset
`define CRCDF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("crcdf assertion failed");

// condition must never be true outside reset
`define CRCDF_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("crcdf forbidden condition seen");

`endif

FILE: rtl/core/crcdf_pkg.sv
// ----------------------------------------------------------------------------
// crcdf_pkg
// shared types, codes and the bytewise crc-16 update of the packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package crcdf_pkg;

  localparam logic [15:0] CrcPoly     = 16'h1021;
  localparam logic [15:0] HeaderReset = 16'hAA55;
  localparam logic [15:0] SeedReset   = 16'hFFFF;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHeaderWord = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCrcSeed    = 2'd1;

  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCrcErr = 1'b1;

  // one classified result waiting for the back end
  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [7:0]  command;
    logic [7:0]  seq_num;
    logic [7:0]  response;
    logic [7:0]  length;
    logic [15:0] crc_calc;
    logic [15:0] crc_got;
  } crcdf_entry_t;

  typedef struct packed {
    logic         valid;
    crcdf_entry_t entry;
  } crcdf_push_t;

  // msb-first crc-16, poly 0x1021, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crc16_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// byte-stream frame receiver with header hunt and crc-16 check
// ----------------------------------------------------------------------------
// usage:
//   rx channel (in_valid_i/in_ready_o, rx_byte_i) takes one received byte per
//   word. the block hunts for the two-byte marker, captures command,
//   sequence, response and length, and checks the trailing big-endian crc.
//   result channel (out_valid_o/out_ready_i) gives one word per payload byte
//   (kind 0) and one frame-end word (kind 1) with frame_status 1 on crc error.
//   config channel (cfg_valid_i/cfg_ready_o) writes header_word (index 0) or
//   crc_seed (index 1); other indexes are dropped. always ready.
// timing:
//   one byte per cycle while the queue has space; each result passes through a
//   queue slot and then the output register before it is valid. the byte path
//   is set by the combinational 8-bit crc update.
// reset:
//   hunting for the marker high byte, queue and output stage empty, header
//   0xaa55, seed 0xffff.
// stall:
//   a two-word queue plus the output register absorb a stalled receiver;
//   once the queue is full in_ready_o drops until words drain.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_deframer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [crcdf_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [15:0]                     cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [7:0]                      rx_byte_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 kind_o,
  output logic [7:0]                           data_byte_o,
  output logic [7:0]                           command_o,
  output logic [7:0]                           sequence_res_o,
  output logic [7:0]                           response_code_o,
  output logic [7:0]                           payload_length_o,
  output logic                                 frame_status_o
);

  logic [15:0] header_word_q;
  logic [15:0] crc_seed_q;

  crcdf_pkg::crcdf_push_t  push;
  crcdf_pkg::crcdf_entry_t q_entry;
  logic                    space;
  logic                    q_valid;
  logic                    pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_word_q <= crcdf_pkg::HeaderReset;
      crc_seed_q    <= crcdf_pkg::SeedReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        crcdf_pkg::CfgHeaderWord: header_word_q <= cfg_data_i;
        crcdf_pkg::CfgCrcSeed:    crc_seed_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  crcdf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .header_word_i (header_word_q),
    .crc_seed_i    (crc_seed_q),
    .space_i       (space),
    .push_o        (push)
  );

  crcdf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  crcdf_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_entry),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .command_o        (command_o),
    .sequence_res_o   (sequence_res_o),
    .response_code_o  (response_code_o),
    .payload_length_o (payload_length_o),
    .frame_status_o   (frame_status_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/crcdf_front.sv
// ----------------------------------------------------------------------------
// crcdf_front
// header hunt, field capture and running crc; classifies each byte
// ----------------------------------------------------------------------------
`default_nettype none

module crcdf_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [7:0]            rx_byte_i,
  input  wire logic [15:0]           header_word_i,
  input  wire logic [15:0]           crc_seed_i,
  input  wire logic                  space_i,
  output crcdf_pkg::crcdf_push_t     push_o
);

  localparam logic [3:0] PhHuntHi  = 4'd0;
  localparam logic [3:0] PhHuntLo  = 4'd1;
  localparam logic [3:0] PhCmd     = 4'd2;
  localparam logic [3:0] PhSeq     = 4'd3;
  localparam logic [3:0] PhRsp     = 4'd4;
  localparam logic [3:0] PhLen     = 4'd5;
  localparam logic [3:0] PhPayload = 4'd6;
  localparam logic [3:0] PhCrcHi   = 4'd7;
  localparam logic [3:0] PhCrcLo   = 4'd8;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  rsp_q, rsp_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic        accept;
  logic        use_seed;
  logic [15:0] crc_upd;
  logic [7:0]  hdr_hi;
  logic [7:0]  hdr_lo;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign hdr_hi     = header_word_i[15:8];
  assign hdr_lo     = header_word_i[7:0];

  // a fresh frame start reseeds the crc, all other updates chain on
  always_comb begin
    if (phase_q == PhHuntLo) begin
      use_seed = (rx_byte_i != hdr_lo);
    end else begin
      use_seed = !(phase_q inside {PhCmd, PhSeq, PhRsp, PhLen, PhPayload});
    end
  end

  assign crc_upd = crcdf_pkg::crc16_byte(use_seed ? crc_seed_i : crc_q, rx_byte_i);

  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    left_d   = left_q;
    cmd_d    = cmd_q;
    seq_d    = seq_q;
    rsp_d    = rsp_q;
    len_d    = len_q;
    crc_hi_d = crc_hi_q;

    push_o.valid          = 1'b0;
    push_o.entry.kind     = crcdf_pkg::KindPayload;
    push_o.entry.data     = rx_byte_i;
    push_o.entry.command  = cmd_q;
    push_o.entry.seq_num  = seq_q;
    push_o.entry.response = rsp_q;
    push_o.entry.length   = len_q;
    push_o.entry.crc_calc = crc_q;
    push_o.entry.crc_got  = {crc_hi_q, rx_byte_i};

    case (phase_q)
      PhHuntLo: begin
        if (rx_byte_i == hdr_lo) begin
          crc_d   = crc_upd;
          phase_d = PhCmd;
        end else if (rx_byte_i == hdr_hi) begin
          crc_d   = crc_upd;
          phase_d = PhHuntLo;
        end else begin
          phase_d = PhHuntHi;
        end
      end
      PhCmd: begin
        cmd_d   = rx_byte_i;
        crc_d   = crc_upd;
        phase_d = PhSeq;
      end
      PhSeq: begin
        seq_d   = rx_byte_i;
        crc_d   = crc_upd;
        phase_d = PhRsp;
      end
      PhRsp: begin
        rsp_d   = rx_byte_i;
        crc_d   = crc_upd;
        phase_d = PhLen;
      end
      PhLen: begin
        len_d   = rx_byte_i;
        left_d  = rx_byte_i;
        crc_d   = crc_upd;
        phase_d = (rx_byte_i == 8'd0) ? PhCrcHi : PhPayload;
      end
      PhPayload: begin
        crc_d        = crc_upd;
        left_d       = left_q - 8'd1;
        phase_d      = (left_q == 8'd1) ? PhCrcHi : PhPayload;
        push_o.valid = accept;
      end
      PhCrcHi: begin
        crc_hi_d = rx_byte_i;
        phase_d  = PhCrcLo;
      end
      PhCrcLo: begin
        push_o.valid      = accept;
        push_o.entry.kind = crcdf_pkg::KindFrameEnd;
        phase_d           = PhHuntHi;
      end
      default: begin
        // hunting for the marker high byte, unused codes land here too
        if (rx_byte_i == hdr_hi) begin
          crc_d   = crc_upd;
          phase_d = PhHuntLo;
        end else begin
          phase_d = PhHuntHi;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHuntHi;
      crc_q    <= crcdf_pkg::SeedReset;
      left_q   <= 8'd0;
      cmd_q    <= 8'd0;
      seq_q    <= 8'd0;
      rsp_q    <= 8'd0;
      len_q    <= 8'd0;
      crc_hi_q <= 8'd0;
    end else if (accept) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      left_q   <= left_d;
      cmd_q    <= cmd_d;
      seq_q    <= seq_d;
      rsp_q    <= rsp_d;
      len_q    <= len_d;
      crc_hi_q <= crc_hi_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/crcdf_queue.sv
// ----------------------------------------------------------------------------
// crcdf_queue
// two-entry queue of classified results between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_packet_deframer_assert.svh"

module crcdf_queue (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire crcdf_pkg::crcdf_push_t  push_i,
  output logic                         space_o,
  input  wire logic                    pop_i,
  output logic                         valid_o,
  output crcdf_pkg::crcdf_entry_t      entry_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  crcdf_pkg::crcdf_entry_t slot_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign space_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      slot_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  `CRCDF_ASSERT(a_count_range, clk_i, rst_ni, count_q <= CntW'(Depth))
  `CRCDF_NEVER(a_push_when_full, clk_i, rst_ni, push_i.valid && !space_o)
  `CRCDF_NEVER(a_pop_when_empty, clk_i, rst_ni, pop_i && !valid_o)
  `CRCDF_ASSERT(a_count_tracks_push, clk_i, rst_ni, $past(push_i.valid && !pop_i) |-> (count_q == $past(count_q) + CntW'(1)))

endmodule

`default_nettype wire

FILE: rtl/core/crcdf_back.sv
// ----------------------------------------------------------------------------
// crcdf_back
// crc compare, result formatting and the registered output stage
// ----------------------------------------------------------------------------
`default_nettype none

module crcdf_back (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire crcdf_pkg::crcdf_entry_t  q_entry_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          kind_o,
  output logic [7:0]                    data_byte_o,
  output logic [7:0]                    command_o,
  output logic [7:0]                    sequence_res_o,
  output logic [7:0]                    response_code_o,
  output logic [7:0]                    payload_length_o,
  output logic                          frame_status_o
);

  logic       out_valid_q;
  logic       kind_q;
  logic [7:0] data_q, cmd_q, seq_q, rsp_q, len_q;
  logic       status_q;
  logic       is_end;
  logic       status_d;

  // load a queued entry whenever the output word is empty or leaving this cycle
  assign pop_o  = q_valid_i && (!out_valid_q || out_ready_i);
  assign is_end = (q_entry_i.kind == crcdf_pkg::KindFrameEnd);

  always_comb begin
    status_d = crcdf_pkg::StatusOk;
    if (is_end && (q_entry_i.crc_got != q_entry_i.crc_calc)) begin
      status_d = crcdf_pkg::StatusCrcErr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      kind_q   <= q_entry_i.kind;
      data_q   <= is_end ? 8'd0 : q_entry_i.data;
      cmd_q    <= q_entry_i.command;
      seq_q    <= q_entry_i.seq_num;
      rsp_q    <= q_entry_i.response;
      len_q    <= q_entry_i.length;
      status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign data_byte_o      = data_q;
  assign command_o        = cmd_q;
  assign sequence_res_o   = seq_q;
  assign response_code_o  = rsp_q;
  assign payload_length_o = len_q;
  assign frame_status_o   = status_q;

endmodule

`default_nettype wire
